// ===== hdl/smlpf_pkg.sv =====
// shared types and constants of the score map local peak finder
package smlpf_pkg;

  localparam int DIM_BITS   = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 2'd2;

  // neighbor availability and edge flags of one window position
  typedef struct packed {
    logic y_ge1;
    logic y_ge2;
    logic x_ge1;
    logic x_ge2;
    logic last_col;
    logic last_row;
  } smlpf_pos_t;

endpackage

// ===== hdl/smlpf_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module smlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== hdl/smlpf_peak.sv =====
// peak decision for the four candidate cells of the 3x3 window
module smlpf_peak #(
  parameter int SCORE_BITS = 16
) (
  input  logic signed [SCORE_BITS-1:0] win [3][3],
  input  logic signed [SCORE_BITS-1:0] threshold,
  input  smlpf_pkg::smlpf_pos_t        pos,
  output logic [3:0]                   hit
);

  localparam int CR [4] = '{1, 1, 2, 2};
  localparam int CC [4] = '{1, 2, 1, 2};

  logic [2:0] rowv;
  logic [2:0] colv;
  logic [3:0] en;
  logic [3:0] ok;

  assign rowv = {1'b1, pos.y_ge1, pos.y_ge2};
  assign colv = {1'b1, pos.x_ge1, pos.x_ge2};

  assign en[0] = pos.y_ge1 && pos.x_ge1;
  assign en[1] = pos.last_col && pos.y_ge1;
  assign en[2] = pos.last_row && pos.x_ge1;
  assign en[3] = pos.last_row && pos.last_col;

  always_comb begin
    int dr;
    int dc;
    for (int k = 0; k < 4; k++) begin
      ok[k] = win[CR[k]][CC[k]] > threshold;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          dr = r - CR[k];
          dc = c - CC[k];
          if (dr >= -1 && dr <= 1 && dc >= -1 && dc <= 1 && !(dr == 0 && dc == 0) &&
              rowv[r] && colv[c]) begin
            if (!(win[CR[k]][CC[k]] > win[r][c])) begin
              ok[k] = 1'b0;
            end
          end
        end
      end
    end
  end

  assign hit = ok & en;

endmodule

// ===== hdl/score_map_local_peak_finder_core.sv =====
// score map local peak finder: 3x3 non-maximum suppression over a raster score stream
// path: a request passes the stage 1 registers, the window and stage 2 registers, then the result buffer
// one request per cycle unless stalled; k peaks hold the result buffer until each is taken
// line stores sit in one ram with a registered read, read at acceptance and written back
// reset: counters, window, valid flags and result mask clear (width 64, height 64, threshold 0);
// the line store ram is not cleared and needs no clearing pass
module score_map_local_peak_finder_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int SCORE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SCORE_BITS-1:0]          in_score,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(MAX_WIDTH)-1:0]          out_peak_x,
  output logic [$clog2(MAX_HEIGHT)-1:0]         out_peak_y,
  output logic signed [SCORE_BITS-1:0]          out_peak_score,
  output logic                                  out_last_in_run,
  input  logic                                  cfg_we,
  input  logic [smlpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((SCORE_BITS > smlpf_pkg::DIM_BITS) ?
                 SCORE_BITS : smlpf_pkg::DIM_BITS)-1:0] cfg_wdata
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int MW  = 2 * SCORE_BITS;
  localparam int DB  = smlpf_pkg::DIM_BITS;

  // configuration
  logic [DB-1:0]                map_width_r;
  logic [DB-1:0]                map_height_r;
  logic signed [SCORE_BITS-1:0] thr_r;
  logic [WDW-1:0]               w_eff;
  logic [HDW-1:0]               h_eff;

  // raster position
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic          last_col;
  logic          last_row;

  // stage 1: line store read
  logic                         s1_vld_r;
  logic [XW-1:0]                s1_x_r;
  logic signed [SCORE_BITS-1:0] s1_score_r;
  smlpf_pkg::smlpf_pos_t        s1_pos_r;
  logic                         s1_fwd_r;
  logic [MW-1:0]                s1_fwd_data_r;
  logic [MW-1:0]                ram_rdata;
  logic [MW-1:0]                line;
  logic signed [SCORE_BITS-1:0] up2;
  logic signed [SCORE_BITS-1:0] up1;
  logic                         mem_we;
  logic [MW-1:0]                mem_wdata;

  // stage 2: window decision
  logic                         s2_vld_r;
  logic [XW-1:0]                s2_x_r;
  logic [YW-1:0]                s2_y_r;
  smlpf_pkg::smlpf_pos_t        s2_pos_r;
  logic [YW-1:0]                s1_y_r;
  logic signed [SCORE_BITS-1:0] win_r [3][3];
  logic [3:0]                   hit;
  logic [3:0]                   hits_v;

  // result buffer
  logic [3:0]                   buf_mask_r;
  logic [3:0]                   buf_mask_nxt;
  logic signed [SCORE_BITS-1:0] buf_score_r [4];
  logic [XW-1:0]                buf_x_r;
  logic [YW-1:0]                buf_y_r;
  logic [1:0]                   sel;
  logic [3:0]                   sel_oh;
  logic [3:0]                   mask_left;
  logic                         buf_free;

  logic in_accept;
  logic out_accept;
  logic s1_go;
  logic s2_go;
  smlpf_pkg::smlpf_pos_t pos_nxt;

  always_comb begin
    if (map_width_r == '0) begin
      w_eff = WDW'(1);
    end else if (32'(map_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(map_width_r);
    end
    if (map_height_r == '0) begin
      h_eff = HDW'(1);
    end else if (32'(map_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(map_height_r);
    end
  end

  assign last_col = (WDW'(x_r) + WDW'(1)) >= w_eff;
  assign last_row = (HDW'(y_r) + HDW'(1)) >= h_eff;

  assign pos_nxt.y_ge1    = y_r != '0;
  assign pos_nxt.y_ge2    = y_r > YW'(1);
  assign pos_nxt.x_ge1    = x_r != '0;
  assign pos_nxt.x_ge2    = x_r > XW'(1);
  assign pos_nxt.last_col = last_col;
  assign pos_nxt.last_row = last_row;

  // handshake and stage advance
  assign out_valid  = buf_mask_r != '0;
  assign out_accept = out_valid && !out_stall;
  assign hits_v     = s2_vld_r ? hit : 4'b0000;

  always_comb begin
    sel = 2'd3;
    case (1'b1)
      buf_mask_r[0]: sel = 2'd0;
      buf_mask_r[1]: sel = 2'd1;
      buf_mask_r[2]: sel = 2'd2;
      default:       sel = 2'd3;
    endcase
  end

  assign sel_oh    = 4'b0001 << sel;
  assign mask_left = buf_mask_r & ~sel_oh;
  assign buf_free  = (buf_mask_r == '0) || (out_accept && mask_left == '0);
  assign s2_go     = !s2_vld_r || (hits_v == '0) || buf_free;
  assign s1_go     = !s1_vld_r || s2_go;
  assign in_stall  = !s1_go;
  assign in_accept = in_valid && s1_go;

  // configuration and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= DB'(64);
      map_height_r <= DB'(64);
      thr_r        <= '0;
      x_r          <= '0;
      y_r          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        smlpf_pkg::REG_MAP_WIDTH: begin
          map_width_r <= cfg_wdata[DB-1:0];
          x_r         <= '0;
          y_r         <= '0;
        end
        smlpf_pkg::REG_MAP_HEIGHT: begin
          map_height_r <= cfg_wdata[DB-1:0];
          x_r          <= '0;
          y_r          <= '0;
        end
        smlpf_pkg::REG_SCORE_THRESHOLD: begin
          thr_r <= cfg_wdata[SCORE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      if (last_col) begin
        x_r <= '0;
        y_r <= last_row ? '0 : y_r + YW'(1);
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
  end

  // line stores: older row in the upper half, newer row in the lower half
  assign line      = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign up2       = line[MW-1:SCORE_BITS];
  assign up1       = line[SCORE_BITS-1:0];
  assign mem_we    = s1_vld_r && s1_go;
  assign mem_wdata = {up1, s1_score_r};

  smlpf_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_x_r),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (x_r),
    .rdata (ram_rdata)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else if (s1_go) begin
      s1_vld_r <= in_accept;
      s1_fwd_r <= in_accept && mem_we && (s1_x_r == x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r        <= x_r;
      s1_y_r        <= y_r;
      s1_score_r    <= in_score;
      s1_pos_r      <= pos_nxt;
      s1_fwd_data_r <= mem_wdata;
    end
  end

  // window and stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (s2_go) begin
        s2_vld_r <= s1_vld_r;
      end
      if (mem_we) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up2;
        win_r[1][2] <= up1;
        win_r[2][2] <= s1_score_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
      s2_pos_r <= s1_pos_r;
    end
  end

  smlpf_peak #(
    .SCORE_BITS (SCORE_BITS)
  ) u_peak (
    .win       (win_r),
    .threshold (thr_r),
    .pos       (s2_pos_r),
    .hit       (hit)
  );

  // result buffer
  always_comb begin
    buf_mask_nxt = buf_mask_r;
    if (hits_v != '0 && buf_free) begin
      buf_mask_nxt = hits_v;
    end else if (out_accept) begin
      buf_mask_nxt = mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_mask_r <= '0;
    end else begin
      buf_mask_r <= buf_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hits_v != '0 && buf_free) begin
      buf_score_r[0] <= win_r[1][1];
      buf_score_r[1] <= win_r[1][2];
      buf_score_r[2] <= win_r[2][1];
      buf_score_r[3] <= win_r[2][2];
      buf_x_r        <= s2_x_r;
      buf_y_r        <= s2_y_r;
    end
  end

  always_comb begin
    case (sel)
      2'd0: begin
        out_peak_x = buf_x_r - XW'(1);
        out_peak_y = buf_y_r - YW'(1);
      end
      2'd1: begin
        out_peak_x = buf_x_r;
        out_peak_y = buf_y_r - YW'(1);
      end
      2'd2: begin
        out_peak_x = buf_x_r - XW'(1);
        out_peak_y = buf_y_r;
      end
      default: begin
        out_peak_x = buf_x_r;
        out_peak_y = buf_y_r;
      end
    endcase
  end

  assign out_peak_score  = buf_score_r[sel];
  assign out_last_in_run = mask_left == '0;

  // checks
  a_fwd_only_in_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_vld_r)
    else $error("forwarded line data without an item in stage 1");

  a_fwd_on_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && mem_we && (s1_x_r == x_r)) |=> s1_fwd_r)
    else $error("same-column write back not forwarded");

  a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WDW'(x_r) < w_eff)
    else $error("column counter beyond map width");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (hits_v != '0 && !buf_free) |=> (s2_vld_r && $stable(s2_x_r) && $stable(s2_y_r)))
    else $error("stage 2 peaks dropped while result buffer busy");

endmodule
